// ===== sv/assert_macros.svh =====
// assertion macros used by the parser unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define LDHP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LDHP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/ldhp_pkg.sv =====
// types and constants of the 6lowpan dispatch header parser
`default_nettype none

package ldhp_pkg;

  // parse phase of the current frame
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DISPATCH = 3'd1,
    PH_MESH     = 3'd2,
    PH_BCAST    = 3'd3,
    PH_FRAG1    = 3'd4,
    PH_FRAGN    = 3'd5,
    PH_DONE     = 3'd6
  } phase_e;

  // header bitmap positions
  localparam logic [4:0] HB_MESH  = 5'h01;
  localparam logic [4:0] HB_BCAST = 5'h02;
  localparam logic [4:0] HB_FRAG1 = 5'h04;
  localparam logic [4:0] HB_FRAGN = 5'h08;
  localparam logic [4:0] HB_NALP  = 5'h10;

  // dispatch patterns
  localparam logic [1:0] NALP_PFX       = 2'b00;
  localparam logic [1:0] MESH_PFX       = 2'b10;
  localparam logic [1:0] MESH_VF        = 2'b11;
  localparam logic [7:0] BCAST_DISPATCH = 8'h50;
  localparam logic [4:0] FRAG1_PFX      = 5'b11000;
  localparam logic [4:0] FRAGN_PFX      = 5'b11100;

  // header lengths in bytes, dispatch byte included
  localparam logic [2:0] MESH_LEN  = 3'd5;
  localparam logic [2:0] BCAST_LEN = 3'd2;
  localparam logic [2:0] FRAG1_LEN = 3'd4;
  localparam logic [2:0] FRAGN_LEN = 3'd5;

  // longest possible header chain
  localparam logic [4:0] MAX_HDR_LEN = 5'd16;

  // full_mode after reset
  localparam logic FULL_MODE_RST = 1'b1;

endpackage

`default_nettype wire

// ===== sv/lowpan_dispatch_header_parser_unit.sv =====
// 6lowpan dispatch header parser: walks leading headers and reports their fields
// a result passes from the input register through the parse stage into the output register
// throughput: one byte per cycle while the parse stage is not stalled; only the beat that ends a frame's headers
//   (first payload byte, frame's last byte or a non-lowpan first byte) gives a result
// an occupied output register that is not taken stalls the parse stage
// reset clears the phase to idle and full_mode to one; bytes before a first
//   byte give nothing
`default_nettype none

module lowpan_dispatch_header_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        full_mode_i,
  // byte input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_byte_i,
  input  wire logic        last_byte_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       header_bits_o,
  output logic [3:0]       hops_left_o,
  output logic [15:0]      origin_addr_o,
  output logic [15:0]      final_addr_o,
  output logic [7:0]       bcast_seqno_o,
  output logic [10:0]      dgram_size_o,
  output logic [15:0]      dgram_tag_o,
  output logic [7:0]       dgram_offset_o,
  output logic [4:0]       header_len_o,
  output logic             truncated_o
);

  // configuration register
  logic full_mode_q;

  // input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       first_q;
  logic       last_q;

  // frame state
  ldhp_pkg::phase_e phase_q, phase_d;
  logic [2:0]  bih_q, bih_d;
  logic [4:0]  seen_q, seen_d;
  logic [3:0]  hops_q, hops_d;
  logic [15:0] origin_q, origin_d;
  logic [15:0] final_q, final_d;
  logic [7:0]  seqno_q, seqno_d;
  logic [10:0] size_q, size_d;
  logic [15:0] tag_q, tag_d;
  logic [7:0]  offset_q, offset_d;
  logic [4:0]  consumed_q, consumed_d;
  logic        fcap_q, fcap_d;

  // result register
  logic out_vld_q;

  // handshake
  logic proc;

  // state as seen by this beat, after a frame restart
  ldhp_pkg::phase_e eff_phase;
  logic [2:0]  eff_bih;
  logic [4:0]  eff_seen;
  logic [3:0]  eff_hops;
  logic [15:0] eff_origin;
  logic [15:0] eff_final;
  logic [7:0]  eff_seqno;
  logic [10:0] eff_size;
  logic [15:0] eff_tag;
  logic [7:0]  eff_offset;
  logic [4:0]  eff_consumed;
  logic        eff_fcap;

  // decode
  logic       active;
  logic       in_disp;
  logic       nalp_byte;
  logic       mesh_byte;
  logic       mesh_ok;
  logic       bcast_hit;
  logic       frag1_hit;
  logic       fragn_hit;
  logic       start_hdr;
  logic       not_lowpan;
  logic [2:0] hdr_len;
  logic [2:0] bih_inc;
  logic       hdr_end;
  logic       emit;
  logic       trunc;

  assign cfg_ready_o = 1'b1;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_mode_q <= ldhp_pkg::FULL_MODE_RST;
    end else if (cfg_valid_i) begin
      full_mode_q <= full_mode_i;
    end
  end

  // parse stage fires when the output register can take a result
  assign proc       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || proc;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= data_byte_i;
      first_q <= first_byte_i;
      last_q  <= last_byte_i;
    end
  end

  // a first byte restarts the frame from a clean state
  assign eff_phase    = first_q ? ldhp_pkg::PH_DISPATCH : phase_q;
  assign eff_bih      = first_q ? 3'd0  : bih_q;
  assign eff_seen     = first_q ? 5'd0  : seen_q;
  assign eff_hops     = first_q ? 4'd0  : hops_q;
  assign eff_origin   = first_q ? 16'd0 : origin_q;
  assign eff_final    = first_q ? 16'd0 : final_q;
  assign eff_seqno    = first_q ? 8'd0  : seqno_q;
  assign eff_size     = first_q ? 11'd0 : size_q;
  assign eff_tag      = first_q ? 16'd0 : tag_q;
  assign eff_offset   = first_q ? 8'd0  : offset_q;
  assign eff_consumed = first_q ? 5'd0  : consumed_q;
  assign eff_fcap     = first_q ? 1'b0  : fcap_q;

  assign active  = (eff_phase != ldhp_pkg::PH_IDLE) && (eff_phase != ldhp_pkg::PH_DONE);
  assign in_disp = (eff_phase == ldhp_pkg::PH_DISPATCH);

  // dispatch byte classification
  assign nalp_byte  = (eff_consumed == 5'd0) && (byte_q[7:6] == ldhp_pkg::NALP_PFX);
  assign mesh_byte  = (eff_consumed == 5'd0) && full_mode_q &&
                      (byte_q[7:6] == ldhp_pkg::MESH_PFX);
  assign mesh_ok    = mesh_byte && (byte_q[5:4] == ldhp_pkg::MESH_VF);
  assign bcast_hit  = full_mode_q && (eff_seen[3:1] == 3'd0) &&
                      (byte_q == ldhp_pkg::BCAST_DISPATCH);
  assign frag1_hit  = (eff_seen[3:2] == 2'd0) && (byte_q[7:3] == ldhp_pkg::FRAG1_PFX);
  assign fragn_hit  = !eff_seen[3] && (byte_q[7:3] == ldhp_pkg::FRAGN_PFX);
  assign not_lowpan = nalp_byte || (mesh_byte && !mesh_ok);
  assign start_hdr  = !not_lowpan && (mesh_ok || bcast_hit || frag1_hit || fragn_hit);

  // header length by phase
  always_comb begin
    case (eff_phase)
      ldhp_pkg::PH_MESH:  hdr_len = ldhp_pkg::MESH_LEN;
      ldhp_pkg::PH_BCAST: hdr_len = ldhp_pkg::BCAST_LEN;
      ldhp_pkg::PH_FRAG1: hdr_len = ldhp_pkg::FRAG1_LEN;
      ldhp_pkg::PH_FRAGN: hdr_len = ldhp_pkg::FRAGN_LEN;
      default:            hdr_len = ldhp_pkg::BCAST_LEN;
    endcase
  end

  assign bih_inc = eff_bih + 3'd1;
  assign hdr_end = (bih_inc >= hdr_len);

  // result due: payload or non-lowpan byte, or the frame's last byte
  assign emit  = active && ((in_disp && !start_hdr) || last_q);
  assign trunc = in_disp ? start_hdr : !hdr_end;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (proc) begin
      if (emit) begin
        phase_d = ldhp_pkg::PH_DONE;
      end else if (active) begin
        if (in_disp) begin
          if (mesh_ok) begin
            phase_d = ldhp_pkg::PH_MESH;
          end else if (bcast_hit) begin
            phase_d = ldhp_pkg::PH_BCAST;
          end else if (frag1_hit) begin
            phase_d = ldhp_pkg::PH_FRAG1;
          end else begin
            phase_d = ldhp_pkg::PH_FRAGN;
          end
        end else if (hdr_end) begin
          phase_d = ldhp_pkg::PH_DISPATCH;
        end else begin
          phase_d = eff_phase;
        end
      end
    end
  end

  // field capture
  always_comb begin
    bih_d      = bih_q;
    seen_d     = seen_q;
    hops_d     = hops_q;
    origin_d   = origin_q;
    final_d    = final_q;
    seqno_d    = seqno_q;
    size_d     = size_q;
    tag_d      = tag_q;
    offset_d   = offset_q;
    consumed_d = consumed_q;
    fcap_d     = fcap_q;
    if (proc) begin
      bih_d      = eff_bih;
      seen_d     = eff_seen;
      hops_d     = eff_hops;
      origin_d   = eff_origin;
      final_d    = eff_final;
      seqno_d    = eff_seqno;
      size_d     = eff_size;
      tag_d      = eff_tag;
      offset_d   = eff_offset;
      consumed_d = eff_consumed;
      fcap_d     = eff_fcap;
      if (active && in_disp) begin
        if (not_lowpan) begin
          seen_d = ldhp_pkg::HB_NALP;
        end else if (start_hdr) begin
          bih_d      = 3'd1;
          consumed_d = eff_consumed + 5'd1;
          if (mesh_ok) begin
            seen_d = eff_seen | ldhp_pkg::HB_MESH;
            hops_d = byte_q[3:0];
          end else if (bcast_hit) begin
            seen_d = eff_seen | ldhp_pkg::HB_BCAST;
          end else if (frag1_hit) begin
            seen_d = eff_seen | ldhp_pkg::HB_FRAG1;
            size_d = {byte_q[2:0], 8'h00};
          end else begin
            seen_d = eff_seen | ldhp_pkg::HB_FRAGN;
            fcap_d = !eff_seen[2];
            if (!eff_seen[2]) begin
              size_d = {byte_q[2:0], 8'h00};
            end
          end
        end
      end else if (active) begin
        consumed_d = eff_consumed + 5'd1;
        bih_d      = hdr_end ? 3'd0 : bih_inc;
        case (eff_phase)
          ldhp_pkg::PH_MESH: begin
            case (eff_bih)
              3'd1:    origin_d[15:8] = byte_q;
              3'd2:    origin_d[7:0]  = byte_q;
              3'd3:    final_d[15:8]  = byte_q;
              3'd4:    final_d[7:0]   = byte_q;
              default: ;
            endcase
          end
          ldhp_pkg::PH_BCAST: begin
            if (eff_bih == 3'd1) begin
              seqno_d = byte_q;
            end
          end
          default: begin
            if ((eff_phase == ldhp_pkg::PH_FRAG1) || eff_fcap) begin
              case (eff_bih)
                3'd1:    size_d[7:0]  = byte_q;
                3'd2:    tag_d[15:8]  = byte_q;
                3'd3:    tag_d[7:0]   = byte_q;
                3'd4:    offset_d     = byte_q;
                default: ;
              endcase
            end
          end
        endcase
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ldhp_pkg::PH_IDLE;
      bih_q      <= 3'd0;
      seen_q     <= 5'd0;
      hops_q     <= 4'd0;
      origin_q   <= 16'd0;
      final_q    <= 16'd0;
      seqno_q    <= 8'd0;
      size_q     <= 11'd0;
      tag_q      <= 16'd0;
      offset_q   <= 8'd0;
      consumed_q <= 5'd0;
      fcap_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      bih_q      <= bih_d;
      seen_q     <= seen_d;
      hops_q     <= hops_d;
      origin_q   <= origin_d;
      final_q    <= final_d;
      seqno_q    <= seqno_d;
      size_q     <= size_d;
      tag_q      <= tag_d;
      offset_q   <= offset_d;
      consumed_q <= consumed_d;
      fcap_q     <= fcap_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      header_bits_o  <= seen_d;
      hops_left_o    <= hops_d;
      origin_addr_o  <= origin_d;
      final_addr_o   <= final_d;
      bcast_seqno_o  <= seqno_d;
      dgram_size_o   <= size_d;
      dgram_tag_o    <= tag_d;
      dgram_offset_o <= offset_d;
      header_len_o   <= consumed_d;
      truncated_o    <= trunc;
    end
  end

  assign out_valid_o = out_vld_q;

  `include "assert_macros.svh"

  `LDHP_ASSERT_IMPLY(a_idle_clean, phase_q == ldhp_pkg::PH_IDLE, (seen_q == 5'd0) && (consumed_q == 5'd0), "idle phase with frame state set")
  `LDHP_ASSERT_ALWAYS(a_len_bound, consumed_q <= ldhp_pkg::MAX_HDR_LEN, "header length beyond longest chain")
  `LDHP_ASSERT_IMPLY(a_disp_aligned, phase_q == ldhp_pkg::PH_DISPATCH, bih_q == 3'd0, "dispatch phase inside a header")
  `LDHP_ASSERT_IMPLY(a_hdr_started, (phase_q == ldhp_pkg::PH_MESH) || (phase_q == ldhp_pkg::PH_BCAST) || (phase_q == ldhp_pkg::PH_FRAG1) || (phase_q == ldhp_pkg::PH_FRAGN), bih_q != 3'd0, "header phase without its dispatch byte")

endmodule

`default_nettype wire

// ===== tb/sv/tb_lowpan_dispatch_header_parser_unit.sv =====
// testbench for the 6lowpan dispatch header parser: directed and random frames checked against a predictor
module tb_lowpan_dispatch_header_parser_unit;

  // one frame report, field by field
  typedef struct packed {
    logic [4:0]  hdr_bits;
    logic [3:0]  hops;
    logic [15:0] origin;
    logic [15:0] dest;
    logic [7:0]  seqno;
    logic [10:0] size;
    logic [15:0] tag;
    logic [7:0]  offset;
    logic [4:0]  hdr_len;
    logic        trunc;
  } frame_report_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    logic [7:0]    data;
    logic          first;
    logic          last;
    logic          typed;
    frame_report_t want;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } frame_beat_t;

  typedef enum int {K_MESH, K_BCAST, K_FRAG1, K_FRAGN} hdr_kind_e;

  localparam frame_report_t NO_REP   = '0;
  localparam frame_report_t NALP_REP = '{hdr_bits: ldhp_pkg::HB_NALP, default: '0};
  localparam frame_report_t CHAIN_REP = '{ldhp_pkg::HB_MESH | ldhp_pkg::HB_BCAST |
                                          ldhp_pkg::HB_FRAG1 | ldhp_pkg::HB_FRAGN, 4'hF,
                                          16'hFFFF, 16'h0000, 8'hFF, 11'h7FF, 16'hABCD,
                                          8'h00, ldhp_pkg::MAX_HDR_LEN, 1'b0};
  localparam int DIR_ROWS = 30;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        full_mode_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        first_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  header_bits_o;
  logic [3:0]  hops_left_o;
  logic [15:0] origin_addr_o;
  logic [15:0] final_addr_o;
  logic [7:0]  bcast_seqno_o;
  logic [10:0] dgram_size_o;
  logic [15:0] dgram_tag_o;
  logic [7:0]  dgram_offset_o;
  logic [4:0]  header_len_o;
  logic        truncated_o;

  lowpan_dispatch_header_parser_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .full_mode_i    (full_mode_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .header_bits_o  (header_bits_o),
    .hops_left_o    (hops_left_o),
    .origin_addr_o  (origin_addr_o),
    .final_addr_o   (final_addr_o),
    .bcast_seqno_o  (bcast_seqno_o),
    .dgram_size_o   (dgram_size_o),
    .dgram_tag_o    (dgram_tag_o),
    .dgram_offset_o (dgram_offset_o),
    .header_len_o   (header_len_o),
    .truncated_o    (truncated_o)
  );

  // directed frames: extremes, special cases, mode off
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_BEAT, 8'h00, 1'b1, 1'b1, 1'b1, NALP_REP},   // not lowpan, reported at once
    '{ROW_BEAT, 8'h12, 1'b0, 1'b0, 1'b0, NO_REP},     // byte after the report
    '{ROW_BEAT, 8'h80, 1'b1, 1'b0, 1'b1, NALP_REP},   // mesh byte without v and f
    '{ROW_BEAT, 8'hBF, 1'b1, 1'b0, 1'b0, NO_REP},     // mesh, hops 15
    '{ROW_BEAT, 8'hFF, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'hFF, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h00, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h00, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h50, 1'b0, 1'b0, 1'b0, NO_REP},     // broadcast
    '{ROW_BEAT, 8'hFF, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'hC7, 1'b0, 1'b0, 1'b0, NO_REP},     // frag1, largest size
    '{ROW_BEAT, 8'hFF, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'hAB, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'hCD, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'hE5, 1'b0, 1'b0, 1'b0, NO_REP},     // fragn after frag1, not captured
    '{ROW_BEAT, 8'h12, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h34, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h56, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h78, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'hC0, 1'b0, 1'b1, 1'b1, CHAIN_REP},  // frag1 out of order is payload
    '{ROW_BEAT, 8'hC3, 1'b1, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h10, 1'b0, 1'b1, 1'b0, NO_REP},     // frame ends inside frag1
    '{ROW_BEAT, 8'h50, 1'b1, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h7F, 1'b0, 1'b1, 1'b0, NO_REP},     // headers end the frame
    '{ROW_BEAT, 8'hC0, 1'b1, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h44, 1'b1, 1'b1, 1'b0, NO_REP},     // restart drops the open frame
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_BEAT, 8'h50, 1'b1, 1'b1, 1'b1, NO_REP},     // mode off: broadcast is payload
    '{ROW_BEAT, 8'hBF, 1'b1, 1'b1, 1'b1, NO_REP},     // mode off: mesh is payload
    '{ROW_CFG,  8'h01, 1'b0, 1'b0, 1'b0, NO_REP}
  };

  // parser state mirrored by the predictor
  logic              mode_full;
  ldhp_pkg::phase_e  ps_phase;
  logic [2:0]  ps_pos;
  logic [4:0]  ps_seen;
  logic [3:0]  ps_hops;
  logic [15:0] ps_origin;
  logic [15:0] ps_dest;
  logic [7:0]  ps_seqno;
  logic [10:0] ps_size;
  logic [15:0] ps_tag;
  logic [7:0]  ps_offset;
  logic [4:0]  ps_used;
  logic        ps_reported;
  logic        ps_fragn_cap;

  frame_report_t pending_reports [$];
  frame_beat_t   frame_q [$];

  int err_count = 0;
  int live_beats = 0;
  int sent_beats = 0;
  int reports_checked = 0;
  int mode_writes = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic flag_error(input string msg);
    err_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got)
      flag_error($sformatf("%s mismatch: expected %0h, actual %0h", name, want, got));
  endtask

  // predictor: frame state handling
  function automatic void clear_frame();
    ps_pos = '0; ps_seen = '0; ps_hops = '0;
    ps_origin = '0; ps_dest = '0; ps_seqno = '0;
    ps_size = '0; ps_tag = '0; ps_offset = '0;
    ps_used = '0; ps_fragn_cap = 1'b0;
  endfunction

  function automatic void open_header(input ldhp_pkg::phase_e ph, input logic [4:0] bit_mask);
    ps_seen = ps_seen | bit_mask;
    ps_phase = ph;
    ps_pos = 3'd1;
    ps_used = ps_used + 5'd1;
  endfunction

  function automatic frame_report_t close_frame(input logic trunc);
    frame_report_t r;
    r = '{ps_seen, ps_hops, ps_origin, ps_dest, ps_seqno, ps_size, ps_tag, ps_offset,
          ps_used, trunc};
    ps_phase = ldhp_pkg::PH_DONE;
    ps_reported = 1'b1;
    return r;
  endfunction

  // predictor: one accepted byte beat, gives at most one frame report
  task automatic predict_report(input logic [7:0] b, input logic f, input logic l,
                                output logic live, output logic got,
                                output frame_report_t rep);
    logic       is_hdr;
    logic [2:0] hlen;
    logic [2:0] k;
    live = 1'b0;
    got = 1'b0;
    rep = '0;
    if (f) begin
      clear_frame();
      ps_phase = ldhp_pkg::PH_DISPATCH;
      ps_reported = 1'b0;
    end
    if (ps_phase == ldhp_pkg::PH_IDLE || ps_phase == ldhp_pkg::PH_DONE || ps_reported) return;
    live = 1'b1;
    if (ps_phase == ldhp_pkg::PH_DISPATCH) begin
      // dispatch byte: header start or first payload byte
      is_hdr = 1'b1;
      if (ps_used == 0 && b[7:6] == ldhp_pkg::NALP_PFX) begin
        ps_seen = ldhp_pkg::HB_NALP;
        is_hdr = 1'b0;
      end else if (ps_used == 0 && mode_full && b[7:6] == ldhp_pkg::MESH_PFX) begin
        if (b[5:4] != ldhp_pkg::MESH_VF) begin
          ps_seen = ldhp_pkg::HB_NALP;
          is_hdr = 1'b0;
        end else begin
          ps_hops = b[3:0];
          open_header(ldhp_pkg::PH_MESH, ldhp_pkg::HB_MESH);
        end
      end else if (mode_full && (ps_seen & (ldhp_pkg::HB_BCAST | ldhp_pkg::HB_FRAG1 |
                                            ldhp_pkg::HB_FRAGN)) == 0 &&
                   b == ldhp_pkg::BCAST_DISPATCH) begin
        open_header(ldhp_pkg::PH_BCAST, ldhp_pkg::HB_BCAST);
      end else if ((ps_seen & (ldhp_pkg::HB_FRAG1 | ldhp_pkg::HB_FRAGN)) == 0 &&
                   b[7:3] == ldhp_pkg::FRAG1_PFX) begin
        ps_size = {b[2:0], 8'h00};
        open_header(ldhp_pkg::PH_FRAG1, ldhp_pkg::HB_FRAG1);
      end else if ((ps_seen & ldhp_pkg::HB_FRAGN) == 0 && b[7:3] == ldhp_pkg::FRAGN_PFX) begin
        ps_fragn_cap = (ps_seen & ldhp_pkg::HB_FRAG1) == 0;
        if (ps_fragn_cap) ps_size = {b[2:0], 8'h00};
        open_header(ldhp_pkg::PH_FRAGN, ldhp_pkg::HB_FRAGN);
      end else begin
        is_hdr = 1'b0;
      end
      if (!is_hdr) begin
        got = 1'b1;
        rep = close_frame(1'b0);
        return;
      end
    end else begin
      // body byte of the current header
      k = ps_pos;
      case (ps_phase)
        ldhp_pkg::PH_MESH: begin
          hlen = ldhp_pkg::MESH_LEN;
          case (k)
            3'd1: ps_origin[15:8] = b;
            3'd2: ps_origin[7:0] = b;
            3'd3: ps_dest[15:8] = b;
            3'd4: ps_dest[7:0] = b;
            default: ;
          endcase
        end
        ldhp_pkg::PH_BCAST: begin
          hlen = ldhp_pkg::BCAST_LEN;
          if (k == 3'd1) ps_seqno = b;
        end
        default: begin
          hlen = (ps_phase == ldhp_pkg::PH_FRAG1) ? ldhp_pkg::FRAG1_LEN : ldhp_pkg::FRAGN_LEN;
          if (ps_phase == ldhp_pkg::PH_FRAG1 || ps_fragn_cap) begin
            case (k)
              3'd1: ps_size[7:0] = b;
              3'd2: ps_tag[15:8] = b;
              3'd3: ps_tag[7:0] = b;
              3'd4: ps_offset = b;
              default: ;
            endcase
          end
        end
      endcase
      ps_used = ps_used + 5'd1;
      ps_pos = k + 3'd1;
      if (ps_pos >= hlen) begin
        ps_pos = '0;
        ps_phase = ldhp_pkg::PH_DISPATCH;
      end
    end
    if (l) begin
      got = 1'b1;
      rep = close_frame(ps_phase != ldhp_pkg::PH_DISPATCH);
    end
  endtask

  // send one byte beat, with bursts and gaps, and queue its report
  task automatic push_beat(input logic [7:0] b, input logic f, input logic l,
                           input logic use_lit, input frame_report_t lit);
    int            gap;
    logic          live;
    logic          got;
    frame_report_t rep;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    data_byte_i = b;
    first_byte_i = f;
    last_byte_i = l;
    do @(posedge clk_i); while (!in_ready_o);
    sent_beats++;
    predict_report(b, f, l, live, got, rep);
    if (live) live_beats++;
    if (got) pending_reports.push_back(use_lit ? lit : rep);
  endtask

  // write full_mode once the block has drained
  task automatic set_mode(input logic value);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    full_mode_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    mode_full = value;
    mode_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic add_header(input hdr_kind_e kind);
    logic [7:0] b;
    int         n;
    case (kind)
      K_MESH: begin
        b = {ldhp_pkg::MESH_PFX, ldhp_pkg::MESH_VF, 4'($urandom_range(0, 15))};
        n = ldhp_pkg::MESH_LEN;
      end
      K_BCAST: begin
        b = ldhp_pkg::BCAST_DISPATCH;
        n = ldhp_pkg::BCAST_LEN;
      end
      K_FRAG1: begin
        b = {ldhp_pkg::FRAG1_PFX, 3'($urandom_range(0, 7))};
        n = ldhp_pkg::FRAG1_LEN;
      end
      default: begin
        b = {ldhp_pkg::FRAGN_PFX, 3'($urandom_range(0, 7))};
        n = ldhp_pkg::FRAGN_LEN;
      end
    endcase
    frame_q.push_back('{b, 1'b0, 1'b0});
    for (int i = 1; i < n; i++) frame_q.push_back('{8'($urandom), 1'b0, 1'b0});
  endtask

  // one random frame: mostly well formed, some out of order, some noise
  task automatic build_frame();
    int pick;
    int hdr_bytes;
    int cut;
    frame_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 1)) add_header(K_MESH);
      if ($urandom_range(0, 1)) add_header(K_BCAST);
      if ($urandom_range(0, 1)) add_header(K_FRAG1);
      if ($urandom_range(0, 1)) add_header(K_FRAGN);
      hdr_bytes = frame_q.size();
      repeat ($urandom_range(0, 4)) frame_q.push_back('{8'($urandom), 1'b0, 1'b0});
      if (frame_q.size() == 0) frame_q.push_back('{8'($urandom), 1'b0, 1'b0});
      // frame ending inside a header
      if (hdr_bytes > 1 && $urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, hdr_bytes - 1);
        frame_q = frame_q[0:cut-1];
      end
      frame_q[0].first = 1'b1;
      if ($urandom_range(0, 9) != 0) frame_q[frame_q.size()-1].last = 1'b1;
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4)) add_header(hdr_kind_e'($urandom_range(0, 3)));
      repeat ($urandom_range(0, 2)) frame_q.push_back('{8'($urandom), 1'b0, 1'b0});
      frame_q[0].first = 1'b1;
      if ($urandom_range(0, 5) != 0) frame_q[frame_q.size()-1].last = 1'b1;
    end else begin
      repeat ($urandom_range(1, 6))
        frame_q.push_back('{8'($urandom), $urandom_range(0, 5) == 0,
                            $urandom_range(0, 3) == 0});
      if ($urandom_range(0, 1)) frame_q[0].first = 1'b1;
    end
  endtask

  // random frames until about target byte beats have gone in
  task automatic run_random(input int target);
    int start;
    start = sent_beats;
    while (sent_beats - start < target) begin
      build_frame();
      foreach (frame_q[i]) push_beat(frame_q[i].data, frame_q[i].first, frame_q[i].last,
                                     1'b0, NO_REP);
    end
  endtask

  // receiver: changing stall styles, plus long hold-offs on request
  initial begin
    int unsigned span;
    int unsigned style;
    int unsigned hold;
    int unsigned tick;
    out_ready_i = 1'b0;
    span = 0;
    style = 0;
    hold = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 400;
      end
      if (span == 0) begin
        span = $urandom_range(16, 200);
        style = $urandom_range(0, 3);
      end
      span--;
      tick++;
      if (hold != 0) begin
        hold--;
        out_ready_i = 1'b0;
      end else begin
        case (style)
          0: out_ready_i = 1'b1;
          1: out_ready_i = $urandom_range(0, 1);
          2: out_ready_i = (tick % 4 == 0);
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    frame_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        flag_error($sformatf("report with none expected: bits %0h len %0d",
                             header_bits_o, header_len_o));
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        check_field("header_bits", 16'(want.hdr_bits), 16'(header_bits_o));
        check_field("hops_left", 16'(want.hops), 16'(hops_left_o));
        check_field("origin_addr", want.origin, origin_addr_o);
        check_field("final_addr", want.dest, final_addr_o);
        check_field("bcast_seqno", 16'(want.seqno), 16'(bcast_seqno_o));
        check_field("dgram_size", 16'(want.size), 16'(dgram_size_o));
        check_field("dgram_tag", want.tag, dgram_tag_o);
        check_field("dgram_offset", 16'(want.offset), 16'(dgram_offset_o));
        check_field("header_len", 16'(want.hdr_len), 16'(header_len_o));
        check_field("truncated", 16'(want.trunc), 16'(truncated_o));
      end
    end
  end

  // stimulus and end of run
  initial begin
    int drain;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    full_mode_i = ldhp_pkg::FULL_MODE_RST;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    first_byte_i = 1'b0;
    last_byte_i = 1'b0;
    mode_full = ldhp_pkg::FULL_MODE_RST;
    ps_phase = ldhp_pkg::PH_IDLE;
    ps_reported = 1'b1;
    clear_frame();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) set_mode(dir_table[i].data[0]);
      else push_beat(dir_table[i].data, dir_table[i].first, dir_table[i].last,
                     dir_table[i].typed, dir_table[i].want);
    end

    // random frames over several mode settings, long output hold-offs in two phases
    hold_req = 1'b1;
    run_random(360);
    set_mode(1'b0);
    run_random(360);
    set_mode(1'b1);
    hold_req = 1'b1;
    run_random(360);
    set_mode(1'b0);
    run_random(370);

    // drain
    @(negedge clk_i);
    in_valid_i = 1'b0;
    drain = 0;
    while (pending_reports.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    foreach (pending_reports[i])
      flag_error($sformatf("report never arrived: bits %0h len %0d",
                           pending_reports[i].hdr_bits, pending_reports[i].hdr_len));

    $display("run: %0d byte beats sent, %0d parsed, %0d frame reports checked, %0d mode writes",
             sent_beats, live_beats, reports_checked, mode_writes);
    $display("covered mesh, broadcast, frag1, fragn chains, truncation, restarts and noise");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
